>>> sv/snq_pkg.sv
// snq_pkg: types and constants for the stochastic norm quantizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package snq_pkg;

    localparam logic [1:0] MODE_BATCH    = 2'd0;
    localparam logic [1:0] MODE_NORM     = 2'd1;
    localparam logic [1:0] MODE_QUANT    = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [39:0] COST_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [30:0] NORM_MAX  = 31'h7FFF_FFFF;
    localparam logic [31:0] GAP_MAX   = 32'hFFFF_FFFF;
    localparam int          VEC_OVERHEAD = 32;
    localparam int          OMEGA_ROUNDS = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_ROOT,
        ST_ROOT_DONE,
        ST_PROD,
        ST_DIV,
        ST_ROUND,
        ST_COST_A,
        ST_COST_B,
        ST_COST_C,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic batch_clear;
        logic square;
        logic accum;
        logic root_start;
        logic root_step;
        logic root_finish;
        logic prod;
        logic div_start;
        logic div_step;
        logic round;
        logic cost_a;
        logic cost_b;
        logic cost_c;
        logic emit_norm;
        logic emit_quant;
    } cmd_t;

    typedef struct packed {
        logic root_done;
        logic div_done;
    } status_t;

    // Elias-omega code length, unrolled over a fixed number of rounds
    function automatic logic [7:0] omega_cost(input logic [39:0] v);
        logic [7:0]  len;
        logic [39:0] t;
        logic [6:0]  b;
        logic        stop;
        len  = 8'd1;
        t    = v;
        stop = 1'b0;
        for (int i = 0; i < OMEGA_ROUNDS; i++)
        begin
            if (!stop && t > 40'd1)
            begin
                b = 7'd0;
                for (int j = 0; j < 40; j++)
                begin
                    if (t[j])
                    begin
                        b = 7'(j + 1);
                    end
                end
                len = len + 8'(b);
                t   = 40'(b - 7'd1);
            end
            else
            begin
                stop = 1'b1;
            end
        end
        return len;
    endfunction

endpackage
`default_nettype wire

>>> sv/snq_ctrl.sv
// snq_ctrl: sequencing state machine for the quantizer.
// Depends on snq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module snq_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [1:0]        in_mode,
    input  wire logic              in_last,
    input  wire logic              out_busy,
    input  wire snq_pkg::status_t  status,
    output logic                   ready,
    output snq_pkg::cmd_t          cmd
);

    snq_pkg::state_t state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic       last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= snq_pkg::ST_IDLE;
            mode_reg  <= 2'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        last_next  = last_reg;
        cmd        = '0;
        ready      = 1'b0;
        unique case (state_reg)
            snq_pkg::ST_IDLE:
            begin
                ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load  = 1'b1;
                    mode_next = in_mode;
                    last_next = in_last;
                    unique case (in_mode)
                        snq_pkg::MODE_BATCH: cmd.batch_clear = 1'b1;
                        snq_pkg::MODE_NORM:  state_next = snq_pkg::ST_SQUARE;
                        snq_pkg::MODE_QUANT: state_next = snq_pkg::ST_PROD;
                        default:             state_next = snq_pkg::ST_IDLE;
                    endcase
                end
            end
            snq_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = snq_pkg::ST_ACCUM;
            end
            snq_pkg::ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = last_reg ? snq_pkg::ST_ROOT : snq_pkg::ST_IDLE;
            end
            snq_pkg::ST_ROOT:
            begin
                cmd.root_start = 1'b1;
                state_next     = snq_pkg::ST_ROOT_DONE;
            end
            snq_pkg::ST_ROOT_DONE:
            begin
                if (status.root_done)
                begin
                    if (!out_busy)
                    begin
                        cmd.root_finish = 1'b1;
                        cmd.emit_norm   = 1'b1;
                        state_next      = snq_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.root_step = 1'b1;
                end
            end
            snq_pkg::ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = snq_pkg::ST_DIV;
            end
            snq_pkg::ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = snq_pkg::ST_ROUND;
            end
            snq_pkg::ST_ROUND:
            begin
                if (status.div_done)
                begin
                    cmd.round  = 1'b1;
                    state_next = snq_pkg::ST_COST_A;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            snq_pkg::ST_COST_A:
            begin
                cmd.cost_a = 1'b1;
                state_next = snq_pkg::ST_COST_B;
            end
            snq_pkg::ST_COST_B:
            begin
                cmd.cost_b = 1'b1;
                state_next = snq_pkg::ST_COST_C;
            end
            snq_pkg::ST_COST_C:
            begin
                cmd.cost_c = 1'b1;
                state_next = snq_pkg::ST_OUT;
            end
            snq_pkg::ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.emit_quant = 1'b1;
                    state_next     = snq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = snq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/snq_datapath.sv
// snq_datapath: square accumulator, bit-serial root and divider, cost counters.
// Depends on snq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module snq_datapath
#(
    parameter int MAX_DIM     = 65536,
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire snq_pkg::cmd_t     cmd,
    input  wire logic [15:0]       quant_levels,
    input  wire logic [23:0]       in_sample,
    input  wire logic [15:0]       in_random,
    input  wire logic              in_last,
    output snq_pkg::status_t       status,
    output logic                   out_kind,
    output logic [15:0]            out_level,
    output logic                   out_negative,
    output logic [30:0]            out_norm,
    output logic [39:0]            out_dense,
    output logic [39:0]            out_sparse,
    output logic                   out_saturated,
    output logic                   out_done
);

    localparam int NZ_BITS = $clog2(MAX_DIM + 1);
    localparam logic [NZ_BITS-1:0] NZ_MAX = NZ_BITS'(MAX_DIM);

    logic [SAMPLE_BITS-1:0] raw;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;

    logic [SAMPLE_BITS-1:0] mag_reg;
    logic                   neg_reg;
    logic [15:0]            rnd_reg;
    logic                   last_reg;
    logic [47:0]            sq_reg;
    logic [63:0]            square_sum_reg;
    logic [30:0]            norm_reg;
    logic [31:0]            gap_count_reg;
    logic [39:0]            dense_total_reg;
    logic [39:0]            sparse_total_reg;
    logic [NZ_BITS-1:0]     nonzero_reg;
    logic                   saturated_reg;

    assign raw = in_sample[SAMPLE_BITS-1:0];
    assign neg = raw[SAMPLE_BITS-1];
    assign mag = neg ? (~raw + SAMPLE_BITS'(1)) : raw;

    // root iteration state
    logic [63:0] rt_v_reg;
    logic [63:0] rt_res_reg;
    logic [5:0]  rt_cnt_reg;
    logic [63:0] rt_bit;
    logic [63:0] rt_trial;

    assign rt_bit   = 64'd1 << {rt_cnt_reg[4:0], 1'b0};
    assign rt_trial = rt_res_reg + rt_bit;

    // divider state: 40-bit product over 31-bit norm
    logic [39:0] prod_reg;
    logic [39:0] quo_reg;
    logic [31:0] rem_reg;
    logic [5:0]  dv_cnt_reg;
    logic [31:0] rem_shift;
    logic [15:0] k_m1;

    assign k_m1      = (quant_levels < 16'd2) ? 16'd1 : quant_levels - 16'd1;
    assign rem_shift = {rem_reg[30:0], prod_reg[6'd39 - dv_cnt_reg]};

    assign status.root_done = rt_cnt_reg[5];
    assign status.div_done  = (dv_cnt_reg == 6'd40);

    // rounding and cost terms
    logic [15:0] level_reg;
    logic [47:0] rnd_n_reg;
    logic [47:0] rem_hi;
    logic [40:0] q_up;
    logic [7:0]  omega_gap_reg;
    logic [7:0]  omega_lvl_reg;
    logic [7:0]  omega_dense_reg;
    logic [31:0] gap_inc;

    assign rem_hi  = {rem_reg[31:0], 16'd0};
    assign q_up    = {1'b0, quo_reg} + 41'd1;
    assign gap_inc = (gap_count_reg == snq_pkg::GAP_MAX) ? gap_count_reg
                                                          : gap_count_reg + 32'd1;

    function automatic logic [40:0] sat_add(input logic [39:0] acc, input logic [39:0] amt);
        logic [40:0] s;
        s = {1'b0, acc} + {1'b0, amt};
        if (s[40] || s[39:0] > snq_pkg::COST_MAX)
        begin
            return {1'b1, snq_pkg::COST_MAX};
        end
        return s;
    endfunction

    logic [40:0] sp_a, dn_a, dn_b, sp_c;
    logic [39:0] tail;

    assign sp_a = sat_add(sparse_total_reg, 40'(omega_gap_reg));
    assign dn_a = sat_add(dense_total_reg, 40'(omega_dense_reg));
    assign tail = 40'(nonzero_reg) + 40'(snq_pkg::VEC_OVERHEAD);
    assign dn_b = sat_add(dense_total_reg, tail);
    assign sp_c = sat_add(sparse_total_reg, tail);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg  <= mag;
            neg_reg  <= neg;
            rnd_reg  <= in_random;
            last_reg <= in_last;
        end
        if (cmd.square)
        begin
            sq_reg <= 48'(mag_reg) * 48'(mag_reg);
        end
        if (cmd.prod)
        begin
            prod_reg <= 40'(mag_reg) * 40'(k_m1);
        end
        if (cmd.div_start)
        begin
            rnd_n_reg <= 48'(rnd_reg) * 48'(norm_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_sum_reg   <= '0;
            norm_reg         <= '0;
            gap_count_reg    <= '0;
            dense_total_reg  <= '0;
            sparse_total_reg <= '0;
            nonzero_reg      <= '0;
            saturated_reg    <= 1'b0;
            rt_v_reg         <= '0;
            rt_res_reg       <= '0;
            rt_cnt_reg       <= 6'b100000;
            quo_reg          <= '0;
            rem_reg          <= '0;
            dv_cnt_reg       <= '0;
            level_reg        <= '0;
            omega_gap_reg    <= '0;
            omega_lvl_reg    <= '0;
            omega_dense_reg  <= '0;
            out_kind         <= 1'b0;
            out_level        <= '0;
            out_negative     <= 1'b0;
            out_norm         <= '0;
            out_dense        <= '0;
            out_sparse       <= '0;
            out_saturated    <= 1'b0;
            out_done         <= 1'b0;
        end
        else
        begin
            if (cmd.batch_clear)
            begin
                square_sum_reg   <= '0;
                norm_reg         <= '0;
                gap_count_reg    <= '0;
                dense_total_reg  <= '0;
                sparse_total_reg <= '0;
                nonzero_reg      <= '0;
                saturated_reg    <= 1'b0;
            end
            if (cmd.accum)
            begin
                if (64'(sq_reg) > ~square_sum_reg)
                begin
                    square_sum_reg <= '1;
                end
                else
                begin
                    square_sum_reg <= square_sum_reg + 64'(sq_reg);
                end
            end
            if (cmd.root_start)
            begin
                rt_v_reg   <= square_sum_reg;
                rt_res_reg <= '0;
                rt_cnt_reg <= 6'd31;
            end
            if (cmd.root_step)
            begin
                if (rt_v_reg >= rt_trial)
                begin
                    rt_v_reg   <= rt_v_reg - rt_trial;
                    rt_res_reg <= (rt_res_reg >> 1) + rt_bit;
                end
                else
                begin
                    rt_res_reg <= rt_res_reg >> 1;
                end
                rt_cnt_reg <= rt_cnt_reg - 6'd1;
            end
            if (cmd.root_finish)
            begin
                square_sum_reg <= '0;
                norm_reg <= (rt_res_reg > 64'(snq_pkg::NORM_MAX)) ? snq_pkg::NORM_MAX
                                                                  : rt_res_reg[30:0];
            end
            if (cmd.div_start)
            begin
                quo_reg    <= '0;
                rem_reg    <= '0;
                dv_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                if (rem_shift >= {1'b0, norm_reg})
                begin
                    rem_reg <= rem_shift - {1'b0, norm_reg};
                    quo_reg <= {quo_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[38:0], 1'b0};
                end
                dv_cnt_reg <= dv_cnt_reg + 6'd1;
            end
            if (cmd.round)
            begin
                if (norm_reg == 31'd0)
                begin
                    level_reg <= '0;
                end
                else if (rnd_n_reg < rem_hi)
                begin
                    level_reg <= (q_up > 41'd65535) ? 16'hFFFF : q_up[15:0];
                end
                else
                begin
                    level_reg <= (quo_reg > 40'd65535) ? 16'hFFFF : quo_reg[15:0];
                end
            end
            if (cmd.cost_a)
            begin
                omega_gap_reg   <= snq_pkg::omega_cost(40'(gap_inc));
                omega_lvl_reg   <= snq_pkg::omega_cost(40'(level_reg));
                omega_dense_reg <= snq_pkg::omega_cost(40'(level_reg) + 40'd1);
                if (level_reg != 16'd0)
                begin
                    gap_count_reg <= '0;
                    if (nonzero_reg < NZ_MAX)
                    begin
                        nonzero_reg <= nonzero_reg + NZ_BITS'(1);
                    end
                end
                else
                begin
                    gap_count_reg <= gap_inc;
                end
            end
            if (cmd.cost_b)
            begin
                if (level_reg != 16'd0)
                begin
                    sparse_total_reg <= sp_a[39:0];
                end
                dense_total_reg <= dn_a[39:0];
                if ((level_reg != 16'd0 && sp_a[40]) || dn_a[40])
                begin
                    saturated_reg <= 1'b1;
                end
                omega_gap_reg <= (level_reg != 16'd0) ? omega_lvl_reg : 8'd0;
            end
            if (cmd.cost_c)
            begin
                if (omega_gap_reg != 8'd0)
                begin
                    sparse_total_reg <= sp_a[39:0];
                    if (sp_a[40])
                    begin
                        saturated_reg <= 1'b1;
                    end
                end
                omega_dense_reg <= 8'd0;
            end
            if (cmd.emit_quant && last_reg)
            begin
                dense_total_reg  <= dn_b[39:0];
                sparse_total_reg <= sp_c[39:0];
                nonzero_reg      <= '0;
                if (dn_b[40] || sp_c[40])
                begin
                    saturated_reg <= 1'b1;
                end
            end
            if (cmd.emit_norm)
            begin
                out_kind      <= 1'b0;
                out_level     <= '0;
                out_negative  <= 1'b0;
                out_norm      <= (rt_res_reg > 64'(snq_pkg::NORM_MAX)) ? snq_pkg::NORM_MAX
                                                                       : rt_res_reg[30:0];
                out_dense     <= dense_total_reg;
                out_sparse    <= sparse_total_reg;
                out_saturated <= saturated_reg;
                out_done      <= 1'b1;
            end
            if (cmd.emit_quant)
            begin
                out_kind      <= 1'b1;
                out_level     <= level_reg;
                out_negative  <= neg_reg;
                out_norm      <= norm_reg;
                out_dense     <= last_reg ? dn_b[39:0] : dense_total_reg;
                out_sparse    <= last_reg ? sp_c[39:0] : sparse_total_reg;
                out_saturated <= saturated_reg | (last_reg & (dn_b[40] | sp_c[40]));
                out_done      <= last_reg;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/stochastic_norm_quantizer.sv
// stochastic_norm_quantizer: top level, stream ports and configuration register.
// Depends on snq_pkg, snq_ctrl, snq_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Stochastic norm quantizer. Items are handled one at a time. A norm-pass
// sample is loaded, squared and accumulated; the last one adds a 32-step
// bit-serial square root. A quantize-pass sample runs the 40-step restoring
// divider of |x|(k-1) by the norm, then three cost steps. A batch-start
// item clears the batch state. Any wait for the output register to
// empty adds to the item that holds a result. The output register frees the
// datapath once a result is held; a new item is taken while it waits.
module stochastic_norm_quantizer
#(
    parameter int MAX_DIM     = 65536,
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // sample[23:0], random_fraction[39:24]
    input  wire logic [39:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // level[15:0], negative[16], vector_norm[47:17], dense[87:48], sparse[127:88],
    // cost_saturated[128], zero pad
    output logic [135:0]     m_tdata,
    // result_kind
    output logic             m_tuser,
    output logic             m_tlast
);

    logic [15:0]      quant_levels_reg;
    logic             in_fire;
    logic             out_busy;
    logic             valid_reg;
    snq_pkg::cmd_t    cmd;
    snq_pkg::status_t status;
    logic             ready;

    logic        o_kind, o_neg, o_sat, o_done;
    logic [15:0] o_level;
    logic [30:0] o_norm;
    logic [39:0] o_dense, o_sparse;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_levels_reg <= 16'd16;
        end
        else if (cfg_we)
        begin
            quant_levels_reg <= cfg_wdata;
        end
    end

    assign s_tready = ready;
    assign in_fire  = s_tvalid & ready;
    assign out_busy = valid_reg & ~m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit_norm || cmd.emit_quant)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    snq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_mode  (s_tuser),
        .in_last  (s_tlast),
        .out_busy (out_busy),
        .status   (status),
        .ready    (ready),
        .cmd      (cmd)
    );

    snq_datapath #(.MAX_DIM(MAX_DIM), .SAMPLE_BITS(SAMPLE_BITS)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .quant_levels  (quant_levels_reg),
        .in_sample     (s_tdata[23:0]),
        .in_random     (s_tdata[39:24]),
        .in_last       (s_tlast),
        .status        (status),
        .out_kind      (o_kind),
        .out_level     (o_level),
        .out_negative  (o_neg),
        .out_norm      (o_norm),
        .out_dense     (o_dense),
        .out_sparse    (o_sparse),
        .out_saturated (o_sat),
        .out_done      (o_done)
    );

    assign m_tvalid = valid_reg;
    assign m_tuser  = o_kind;
    assign m_tlast  = o_done;
    assign m_tdata  = {7'd0, o_sat, o_sparse, o_dense, o_norm, o_neg, o_level};

endmodule
`default_nettype wire
